// ===== src/pfa_pkg.sv =====
// pfa_pkg: shared types, constants and helpers for the page frame allocator
// no dependencies; imported by pfa_ctrl, pfa_datapath and the top level
`timescale 1ns / 1ps

package pfa_pkg;

    // frame geometry
    localparam int NUM_PAGES   = 128;
    localparam int IDX_W       = $clog2(NUM_PAGES);
    localparam int TOT_W       = $clog2(NUM_PAGES + 1);
    localparam int CNT_W       = TOT_W;
    localparam int ADDR_W      = 29;
    localparam int FRAME_SHIFT = 21;                       // 2 MB frames
    localparam int ADDR_HI_W   = ADDR_W - FRAME_SHIFT;
    localparam logic [ADDR_W-1:0] FRAME_BASE = 29'h1000_0000;

    // operation codes carried in the func field
    localparam logic [1:0] FN_INIT  = 2'd0;
    localparam logic [1:0] FN_ALLOC = 2'd1;
    localparam logic [1:0] FN_FREE  = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] count;
        logic [6:0] page;
    } pfa_in_t;

    typedef struct packed {
        logic              status;
        logic [6:0]        head_page;
        logic [ADDR_W-1:0] page_addr;
        logic [6:0]        next_page;
        logic              next_valid;
        logic [7:0]        free_count;
    } pfa_out_t;

    // one link entry: frame index plus valid bit (clear means null)
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             ok;
    } link_t;

    localparam int LINK_W = $bits(link_t);

    // datapath operations issued by the controller, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_WR,
        OP_INIT_END,
        OP_CUR_HEAD,
        OP_VAL_STEP,
        OP_POP_STEP,
        OP_POP_END,
        OP_CUR_PAGE,
        OP_PUSH_STEP,
        OP_READ_PAGE,
        OP_KEEP_LINK,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_FAIL,
        RES_ALLOC,
        RES_READ
    } res_kind_t;

    typedef struct packed {
        dp_op_t    op;
        res_kind_t res;
    } dp_cmd_t;

    typedef struct packed {
        logic alloc_bad;
        logic cnt_eq_count;
        logic cnt_full;
        logic node_ok;
        logic page_oob;
        logic out_free;
    } dp_sts_t;

    // physical address of a frame, wrapped to the address width
    function automatic logic [ADDR_W-1:0] frame_addr(input logic [ADDR_HI_W-1:0] idx);
        logic [ADDR_HI_W-1:0] hi;
        hi = idx + FRAME_BASE[ADDR_W-1:FRAME_SHIFT];
        return {hi, {FRAME_SHIFT{1'b0}}};
    endfunction

endpackage

// ===== src/pfa_ram.sv =====
// pfa_ram: generic single write port, single read port ram with registered read
// no dependencies; a read of the address being written returns the old word
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/pfa_ctrl.sv =====
// pfa_ctrl: sequencer that steps the allocator datapath through each operation
// depends on pfa_pkg for command and status types
`timescale 1ns / 1ps

module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_func,
    output logic       s_ready,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_A_CHK,
        ST_A_VAL,
        ST_A_POP,
        ST_F_CHK,
        ST_F_WALK,
        ST_R_RD,
        ST_R_WAIT,
        ST_DONE
    } state_t;

    state_t    state_reg, state_next;
    logic      s_ready_reg, s_ready_next;
    res_kind_t res_reg, res_next;
    dp_op_t    op;

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        res_next     = res_reg;
        op           = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    op           = OP_LOAD;
                    s_ready_next = 1'b0;
                    unique case (s_func)
                        FN_INIT:  state_next = ST_INIT;
                        FN_ALLOC: state_next = ST_A_CHK;
                        FN_FREE:  state_next = ST_F_CHK;
                        FN_READ:  state_next = ST_R_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                if (sts.cnt_full) begin
                    op         = OP_INIT_END;
                    res_next   = RES_PLAIN;
                    state_next = ST_DONE;
                end else begin
                    op = OP_INIT_WR;
                end
            end
            ST_A_CHK: begin
                if (sts.alloc_bad) begin
                    res_next   = RES_FAIL;
                    state_next = ST_DONE;
                end else begin
                    op         = OP_CUR_HEAD;
                    state_next = ST_A_VAL;
                end
            end
            ST_A_VAL: begin
                priority if (sts.cnt_eq_count) begin
                    op         = OP_CUR_HEAD;
                    state_next = ST_A_POP;
                end else if (!sts.node_ok) begin
                    res_next   = RES_FAIL;
                    state_next = ST_DONE;
                end else begin
                    op = OP_VAL_STEP;
                end
            end
            ST_A_POP: begin
                if (sts.cnt_eq_count) begin
                    op         = OP_POP_END;
                    res_next   = RES_ALLOC;
                    state_next = ST_DONE;
                end else begin
                    op = OP_POP_STEP;
                end
            end
            ST_F_CHK: begin
                if (sts.page_oob) begin
                    res_next   = RES_PLAIN;
                    state_next = ST_DONE;
                end else begin
                    op         = OP_CUR_PAGE;
                    state_next = ST_F_WALK;
                end
            end
            ST_F_WALK: begin
                if (sts.cnt_full || !sts.node_ok) begin
                    res_next   = RES_PLAIN;
                    state_next = ST_DONE;
                end else begin
                    op = OP_PUSH_STEP;
                end
            end
            ST_R_RD: begin
                op         = OP_READ_PAGE;
                state_next = ST_R_WAIT;
            end
            ST_R_WAIT: begin
                op         = OP_KEEP_LINK;
                res_next   = RES_READ;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    op           = OP_RESULT;
                    s_ready_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            res_reg     <= RES_PLAIN;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            res_reg     <= res_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign cmd.op  = op;
    assign cmd.res = res_reg;

endmodule

// ===== src/pfa_datapath.sv =====
// pfa_datapath: list registers, link memory, walk counter and result register
// depends on pfa_pkg and pfa_ram
`timescale 1ns / 1ps

module pfa_datapath
    import pfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  dp_cmd_t  cmd,
    output dp_sts_t  sts,
    input  pfa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pfa_out_t m_data
);

    pfa_in_t          op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    link_t            cur_reg, cur_next;
    link_t            chain_reg, chain_next;
    link_t            head_reg, head_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             m_valid_reg, m_valid_next;
    pfa_out_t         m_data_reg, m_data_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_wr_addr;
    link_t             ram_wr_link;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [LINK_W-1:0] ram_rd_data;
    link_t             rd_link;

    link_t            node;
    logic             page_oob;
    logic [IDX_W-1:0] page_idx;
    logic [TOT_W-1:0] total_inc;

    pfa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_link),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_link = link_t'(ram_rd_data);

    // first node of a walk comes from cur, later ones from the previous read
    assign node      = (cnt_reg == '0) ? cur_reg : rd_link;
    assign page_oob  = 32'(op_reg.page) >= NUM_PAGES;
    assign page_idx  = IDX_W'(op_reg.page);
    assign total_inc = (total_reg < TOT_W'(NUM_PAGES)) ? total_reg + 1'b1 : total_reg;

    assign sts.alloc_bad    = (op_reg.count == '0) || (32'(op_reg.count) > 32'(total_reg));
    assign sts.cnt_eq_count = 32'(cnt_reg) == 32'(op_reg.count);
    assign sts.cnt_full     = 32'(cnt_reg) == NUM_PAGES;
    assign sts.node_ok      = node.ok;
    assign sts.page_oob     = page_oob;
    assign sts.out_free     = !m_valid_reg || m_ready;

    // link memory port control
    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = node.idx;
        ram_wr_link = chain_reg;
        ram_rd_addr = node.idx;
        unique case (cmd.op)
            OP_INIT_WR: begin
                ram_we      = 1'b1;
                ram_wr_addr = IDX_W'(cnt_reg);
                ram_wr_link = '{idx: IDX_W'(cnt_reg - 1'b1), ok: (cnt_reg != '0)};
            end
            OP_POP_STEP: begin
                ram_we      = 1'b1;
                ram_wr_link = chain_reg;
            end
            OP_PUSH_STEP: begin
                ram_we      = 1'b1;
                ram_wr_link = head_reg;
            end
            OP_READ_PAGE: begin
                ram_rd_addr = page_idx;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        chain_next   = chain_reg;
        head_next    = head_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                op_next  = s_data;
                cnt_next = '0;
            end
            OP_INIT_WR: begin
                cnt_next = cnt_reg + 1'b1;
            end
            OP_INIT_END: begin
                head_next  = '{idx: IDX_W'(NUM_PAGES - 1), ok: 1'b1};
                total_next = TOT_W'(NUM_PAGES);
            end
            OP_CUR_HEAD: begin
                cur_next   = head_reg;
                cnt_next   = '0;
                chain_next = '{idx: '0, ok: 1'b0};
            end
            OP_VAL_STEP: begin
                cnt_next = cnt_reg + 1'b1;
            end
            OP_POP_STEP: begin
                chain_next = '{idx: node.idx, ok: 1'b1};
                cnt_next   = cnt_reg + 1'b1;
            end
            OP_POP_END: begin
                head_next  = node;
                total_next = total_reg - TOT_W'(op_reg.count);
            end
            OP_CUR_PAGE: begin
                cur_next = '{idx: page_idx, ok: 1'b1};
                cnt_next = '0;
            end
            OP_PUSH_STEP: begin
                head_next  = '{idx: node.idx, ok: 1'b1};
                total_next = total_inc;
                cnt_next   = cnt_reg + 1'b1;
            end
            OP_KEEP_LINK: begin
                cur_next = rd_link;
            end
            OP_RESULT: begin
                m_valid_next           = 1'b1;
                m_data_next            = '0;
                m_data_next.free_count = 8'(total_reg);
                unique case (cmd.res)
                    RES_FAIL: begin
                        m_data_next.status = 1'b1;
                    end
                    RES_ALLOC: begin
                        m_data_next.head_page = 7'(chain_reg.idx);
                        m_data_next.page_addr = frame_addr(ADDR_HI_W'(chain_reg.idx));
                    end
                    RES_READ: begin
                        m_data_next.head_page = op_reg.page;
                        m_data_next.page_addr = frame_addr(ADDR_HI_W'(op_reg.page));
                        if (!page_oob && cur_reg.ok) begin
                            m_data_next.next_page  = 7'(cur_reg.idx);
                            m_data_next.next_valid = 1'b1;
                        end
                    end
                    default: begin
                        m_data_next.status = 1'b0;
                    end
                endcase
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '{idx: '0, ok: 1'b0};
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        cur_reg    <= cur_next;
        chain_reg  <= chain_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/page_frame_free_list_allocator.sv =====
// page_frame_free_list_allocator: top level of the page frame allocator
// depends on pfa_pkg, pfa_ctrl and pfa_datapath (which holds pfa_ram)
//
//   channel   direction  handshake           word
//   s_        in         s_valid / s_ready   pfa_in_t  {func, count, page}
//   m_        out        m_valid / m_ready   pfa_out_t {status, head_page, page_addr,
//                                                       next_page, next_valid, free_count}
//
// one word at a time; init links every frame, allocate checks and then pops
//   count frames (refused early on zero or too large a count), free walks the
//   chain from page, read fetches one link; each walk step is one link memory access
// synchronous active-low reset empties the free list; link memory is not cleared
// a finished word waits in the output register while m_ready is low; the next
// word is taken meanwhile and its result is held until the register drains
`timescale 1ns / 1ps

module page_frame_free_list_allocator
    import pfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pfa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pfa_out_t m_data
);

    // controller to datapath commands and the status flags going back
    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: decodes func on accept and walks the list one step a cycle
    pfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // free list head, frame count, link memory and the output register
    pfa_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
